// ----- src/rnc_pkg.sv -----
// ----------------------------------------------------------------------------
// rnc_pkg: shared constants and types of the radix number converter
// Value and stack sizes, status codes, register indexes and the control
// and status bundles between the control unit and the serial datapath.
// ----------------------------------------------------------------------------
package rnc_pkg;

  localparam int VALUE_BITS = 64;
  localparam int MAX_DIGITS = 64;

  localparam int CNT_W  = $clog2(VALUE_BITS);
  localparam int DC_W   = $clog2(MAX_DIGITS + 1);
  localparam int STK_AW = $clog2(MAX_DIGITS);
  localparam int BASE_W = 6;
  localparam int CH_W   = 8;

  localparam logic [BASE_W-1:0] BASE_RESET = 6'd10;
  localparam logic [BASE_W-1:0] BASE_MIN   = 6'd2;
  localparam logic [BASE_W-1:0] BASE_MAX   = 6'd36;

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_BAD = 2'd1;
  localparam logic [1:0] ST_OVF = 2'd2;

  localparam logic CFG_IN_BASE  = 1'b0;
  localparam logic CFG_OUT_BASE = 1'b1;

  typedef struct packed {
    logic mul;
    logic div;
    logic clr;
  } acc_cmd_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic              nz;
    logic [BASE_W-1:0] rem;
  } acc_sts_t;

endpackage

// ----- src/radix_number_converter_unit.sv -----
// ----------------------------------------------------------------------------
// radix_number_converter_unit: ascii radix converter, bases 2 to 36
// Digit characters run a bit-serial multiply-accumulate. Whitespace is
// skipped; bad characters, overflows and zero-value ends emit one status word
// through the S_ONE state, which waits for a free output slot. A number end
// runs a serial divide by the base per output digit onto the digit stack,
// then pops one word per digit through S_RD and S_POP.
// Synchronous active-low reset: bases to 10, accumulator cleared, no ram pass.
// ----------------------------------------------------------------------------
module radix_number_converter_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [5:0]  cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // ch
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // digit_char
  output logic [2:0]  out_tuser,  // status[1:0], digit_valid
  output logic        out_tlast   // last
);
  import rnc_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_RD   = 3'd3;
  localparam logic [2:0] S_POP  = 3'd4;
  localparam logic [2:0] S_ONE  = 3'd5;

  logic [2:0]        state_r, state_nxt;
  logic [BASE_W-1:0] in_base_r, out_base_r;
  logic [BASE_W-1:0] base_in, base_out;
  logic [BASE_W-1:0] d_r, d_nxt;
  logic [DC_W-1:0]   cnt_r, cnt_nxt;
  logic [DC_W-1:0]   cnt_m1;
  logic [1:0]        stat_r, stat_nxt;

  logic              out_tvalid_r;
  logic [CH_W-1:0]   out_char_r;
  logic              out_dv_r;
  logic [1:0]        out_st_r;
  logic              out_last_r;

  acc_cmd_t          cmd;
  acc_sts_t          acc_sts;

  logic              accept, slot_free, load_dig, load_one;
  logic              ch_zero, ch_digit, ch_space;
  logic [BASE_W-1:0] ch_val;
  logic              ram_we, ram_re;
  logic [BASE_W-1:0] ram_rdata;
  logic [CH_W-1:0]   dig_ascii;

  // base clamping
  always_comb begin
    base_in = in_base_r;
    if (in_base_r < BASE_MIN) begin
      base_in = BASE_MIN;
    end else if (in_base_r > BASE_MAX) begin
      base_in = BASE_MAX;
    end
    base_out = out_base_r;
    if (out_base_r < BASE_MIN) begin
      base_out = BASE_MIN;
    end else if (out_base_r > BASE_MAX) begin
      base_out = BASE_MAX;
    end
  end

  // character decode
  always_comb begin
    ch_zero  = in_tdata == 8'h00;
    ch_space = (in_tdata == 8'h20) || ((in_tdata >= 8'h09) && (in_tdata <= 8'h0D));
    ch_digit = 1'b1;
    ch_val   = '0;
    if ((in_tdata >= 8'h30) && (in_tdata <= 8'h39)) begin
      ch_val = BASE_W'(in_tdata - 8'h30);
    end else if ((in_tdata >= 8'h41) && (in_tdata <= 8'h5A)) begin
      ch_val = BASE_W'(in_tdata - 8'h37);
    end else if ((in_tdata >= 8'h61) && (in_tdata <= 8'h7A)) begin
      ch_val = BASE_W'(in_tdata - 8'h57);
    end else begin
      ch_digit = 1'b0;
    end
  end

  assign dig_ascii = {2'b00, ram_rdata} + ((ram_rdata > 6'd9) ? 8'h37 : 8'h30);
  assign cnt_m1    = cnt_r - DC_W'(1);
  assign slot_free = !out_tvalid_r || out_tready;
  assign in_tready = state_r == S_IDLE;
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    state_nxt = state_r;
    d_nxt     = d_r;
    cnt_nxt   = cnt_r;
    stat_nxt  = stat_r;
    cmd       = '0;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    load_dig  = 1'b0;
    load_one  = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (ch_zero || (ch_space && acc_sts.nz)) begin
            if (acc_sts.nz) begin
              cmd.div   = 1'b1;
              cnt_nxt   = '0;
              state_nxt = S_DIV;
            end else begin
              stat_nxt  = ST_OK;
              state_nxt = S_ONE;
            end
          end else if (ch_digit) begin
            cmd.mul   = 1'b1;
            d_nxt     = ch_val;
            state_nxt = S_MUL;
          end else if (!ch_space) begin
            cmd.clr   = 1'b1;
            stat_nxt  = ST_BAD;
            state_nxt = S_ONE;
          end
        end
      end
      S_MUL: begin
        if (acc_sts.done) begin
          if (acc_sts.rem != '0) begin
            cmd.clr   = 1'b1;
            stat_nxt  = ST_OVF;
            state_nxt = S_ONE;
          end else if (d_r >= base_in) begin
            cmd.clr   = 1'b1;
            stat_nxt  = ST_BAD;
            state_nxt = S_ONE;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_DIV: begin
        if (acc_sts.done) begin
          ram_we  = 1'b1;
          cnt_nxt = cnt_r + DC_W'(1);
          if (acc_sts.nz && (cnt_r < DC_W'(MAX_DIGITS - 1))) begin
            cmd.div = 1'b1;
          end else begin
            cmd.clr   = 1'b1;
            state_nxt = S_RD;
          end
        end
      end
      S_RD: begin
        ram_re    = 1'b1;
        state_nxt = S_POP;
      end
      S_POP: begin
        if (slot_free) begin
          load_dig  = 1'b1;
          cnt_nxt   = cnt_m1;
          state_nxt = (cnt_r == DC_W'(1)) ? S_IDLE : S_RD;
        end
      end
      S_ONE: begin
        if (slot_free) begin
          load_one  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      in_base_r    <= BASE_RESET;
      out_base_r   <= BASE_RESET;
      cnt_r        <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (cfg_we) begin
        case (cfg_addr)
          CFG_IN_BASE:  in_base_r  <= cfg_wdata;
          CFG_OUT_BASE: out_base_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (load_dig || load_one) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    d_r    <= d_nxt;
    stat_r <= stat_nxt;
    if (load_dig) begin
      out_char_r <= dig_ascii;
      out_dv_r   <= 1'b1;
      out_st_r   <= ST_OK;
      out_last_r <= cnt_r == DC_W'(1);
    end else if (load_one) begin
      out_char_r <= '0;
      out_dv_r   <= 1'b0;
      out_st_r   <= stat_r;
      out_last_r <= 1'b1;
    end
  end

  rnc_acc u_acc (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd),
    .base  ((state_r == S_MUL) ? base_in : base_out),
    .digit (ch_val),
    .sts   (acc_sts)
  );

  rnc_ram #(
    .WIDTH (BASE_W),
    .DEPTH (MAX_DIGITS)
  ) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cnt_r[STK_AW-1:0]),
    .wdata (acc_sts.rem),
    .re    (ram_re),
    .raddr (cnt_m1[STK_AW-1:0]),
    .rdata (ram_rdata)
  );

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_char_r;
  assign out_tuser  = {out_st_r, out_dv_r};
  assign out_tlast  = out_last_r;

  a_idle_acc_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !acc_sts.busy)
    else $error("datapath busy while idle");

  a_push_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (cnt_r < DC_W'(MAX_DIGITS)))
    else $error("digit stack overrun");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_POP) || (state_r == S_RD)) |-> (cnt_r != '0))
    else $error("pop from empty digit stack");

  a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (load_dig && (cnt_r == DC_W'(1))) |=> (state_r == S_IDLE) && (cnt_r == '0))
    else $error("emission did not finish on last word");

endmodule

// ----- src/rnc_ram.sv -----
// ----------------------------------------------------------------------------
// rnc_ram: generic single-write, single-read ram
// One write port and one read port with a registered, enabled read.
// ----------------------------------------------------------------------------
module rnc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- src/rnc_acc.sv -----
// ----------------------------------------------------------------------------
// rnc_acc: bit-serial accumulator datapath
// Holds the value in a shift register. Multiply-accumulate runs lsb first
// with a narrow carry; division by the base runs msb first with a narrow
// remainder. One bit per cycle either way.
// ----------------------------------------------------------------------------
module rnc_acc (
  input  logic                     clk,
  input  logic                     rst_n,
  input  rnc_pkg::acc_cmd_t        cmd,
  input  logic [rnc_pkg::BASE_W-1:0] base,
  input  logic [rnc_pkg::BASE_W-1:0] digit,
  output rnc_pkg::acc_sts_t        sts
);
  import rnc_pkg::*;

  localparam logic [1:0] M_IDLE = 2'd0;
  localparam logic [1:0] M_MUL  = 2'd1;
  localparam logic [1:0] M_DIV  = 2'd2;

  logic [VALUE_BITS-1:0] acc_r, acc_nxt;
  logic [BASE_W-1:0]     rem_r, rem_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [1:0]            mode_r, mode_nxt;
  logic                  nz_r, nz_nxt;
  logic                  done_r, done_nxt;

  logic [BASE_W:0] mul_sum;
  logic [BASE_W:0] div_part;
  logic [BASE_W:0] div_rem;
  logic            div_ge;
  logic            last_bit;

  always_comb begin
    mul_sum  = {1'b0, rem_r} + (acc_r[0] ? {1'b0, base} : '0);
    div_part = {rem_r, acc_r[VALUE_BITS-1]};
    div_ge   = div_part >= {1'b0, base};
    div_rem  = div_ge ? (div_part - {1'b0, base}) : div_part;
    last_bit = cnt_r == CNT_W'(VALUE_BITS - 1);

    acc_nxt  = acc_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    mode_nxt = mode_r;
    nz_nxt   = nz_r;
    done_nxt = 1'b0;

    case (mode_r)
      M_MUL: begin
        acc_nxt = {mul_sum[0], acc_r[VALUE_BITS-1:1]};
        rem_nxt = mul_sum[BASE_W:1];
        nz_nxt  = nz_r | mul_sum[0];
        cnt_nxt = cnt_r + CNT_W'(1);
        if (last_bit) begin
          mode_nxt = M_IDLE;
          done_nxt = 1'b1;
        end
      end
      M_DIV: begin
        acc_nxt = {acc_r[VALUE_BITS-2:0], div_ge};
        rem_nxt = div_rem[BASE_W-1:0];
        nz_nxt  = nz_r | div_ge;
        cnt_nxt = cnt_r + CNT_W'(1);
        if (last_bit) begin
          mode_nxt = M_IDLE;
          done_nxt = 1'b1;
        end
      end
      default: ;
    endcase

    if (cmd.clr) begin
      acc_nxt  = '0;
      nz_nxt   = 1'b0;
      mode_nxt = M_IDLE;
    end
    if (cmd.mul) begin
      mode_nxt = M_MUL;
      rem_nxt  = digit;
      nz_nxt   = 1'b0;
      cnt_nxt  = '0;
    end
    if (cmd.div) begin
      mode_nxt = M_DIV;
      rem_nxt  = '0;
      nz_nxt   = 1'b0;
      cnt_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r  <= '0;
      mode_r <= M_IDLE;
      nz_r   <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
      rem_r  <= '0;
    end else begin
      acc_r  <= acc_nxt;
      mode_r <= mode_nxt;
      nz_r   <= nz_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
      rem_r  <= rem_nxt;
    end
  end

  assign sts.busy = mode_r != M_IDLE;
  assign sts.done = done_r;
  assign sts.nz   = nz_r;
  assign sts.rem  = rem_r;

endmodule
